// ----- hw/rtl/spq_pkg.sv -----
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int LEVELS   = 5;

    localparam int ID_W     = 16;
    localparam int PRIO_W   = 3;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    localparam int PTR_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int LVL_W    = $clog2(LEVELS);
    localparam int ADDR_W   = LVL_W + PTR_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_ENQ   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_DEQ   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    // Saturate the requested priority into 1..LEVELS and return its level index.
    function automatic logic [LVL_W-1:0] level_of(input logic [PRIO_W-1:0] p);
        logic [LVL_W-1:0] idx;
        if (p == '0)
        begin
            idx = '0;
        end
        else if (int'(p) > LEVELS)
        begin
            idx = LVL_W'(LEVELS - 1);
        end
        else
        begin
            idx = LVL_W'(int'(p) - 1);
        end
        return idx;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(CAPACITY - 1))
        begin
            n = '0;
        end
        else
        begin
            n = p + PTR_W'(1);
        end
        return n;
    endfunction

    function automatic logic [OCC_W-1:0] occ_of(input logic [CNT_W-1:0] c);
        return OCC_W'(c);
    endfunction

endpackage

// ----- hw/rtl/spq_ram.sv -----
module spq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/stable_priority_queue_core.sv -----
// Stable bounded priority queue of 16-bit process ids.
// Input channel s_*: s_tuser[0] is the operation (0 enqueue, 1 dequeue),
// s_tdata carries process_id and priority_req. Priorities run 1..5, higher
// leaves first; out-of-range values saturate. Equal priorities leave in
// arrival order.
// Output channel m_*: one result item per input item. m_tuser is the status
// (0 enqueued, 1 dequeued, 2 dequeue on empty, 3 enqueue on full), m_tdata
// carries the removed id and priority (zero when nothing removed) and the
// occupancy after the operation.
// Entries sit in one RAM holding a circular FIFO per priority level; head,
// tail and fill counts per level live in flip-flops.
// An enqueue or a refused operation writes its result to the output register on
// acceptance; a dequeue first waits in ST_READ for the registered RAM read.
// Throughput: one enqueue per cycle unless the output stalls; no item is taken in ST_READ.
// An item is taken only while the output register is empty or being drained,
// so a stalled m_tready holds the result and stops s_tready.
// Reset empties the queue at once; no clearing pass is needed.
module stable_priority_queue_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] process_id, [18:16] priority_req, [23:19] zero
    input  logic [0:0]  s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] out_id, [18:16] out_priority, [23:19] occupancy
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int CNT_W = spq_pkg::CNT_W;
    localparam int PTR_W = spq_pkg::PTR_W;
    localparam int LVL_W = spq_pkg::LVL_W;
    localparam int LEVELS = spq_pkg::LEVELS;

    spq_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] lvl_cnt_reg  [LEVELS];
    logic [CNT_W-1:0] lvl_cnt_next [LEVELS];
    logic [PTR_W-1:0] head_reg  [LEVELS];
    logic [PTR_W-1:0] head_next [LEVELS];
    logic [PTR_W-1:0] tail_reg  [LEVELS];
    logic [PTR_W-1:0] tail_next [LEVELS];
    logic [LVL_W-1:0] deq_lvl_reg, deq_lvl_next;

    logic                          out_valid_reg, out_valid_next;
    logic [spq_pkg::STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [spq_pkg::ID_W-1:0]      out_id_reg, out_id_next;
    logic [spq_pkg::PRIO_W-1:0]    out_prio_reg, out_prio_next;
    logic [spq_pkg::OCC_W-1:0]     out_occ_reg, out_occ_next;

    logic                       accept;
    logic                       is_deq;
    logic                       full;
    logic                       any_held;
    logic [LVL_W-1:0]           enq_lvl;
    logic [LVL_W-1:0]           top_lvl;
    logic                       ram_we;
    logic                       ram_re;
    logic [spq_pkg::ADDR_W-1:0] ram_waddr;
    logic [spq_pkg::ADDR_W-1:0] ram_raddr;
    logic [spq_pkg::ID_W-1:0]   ram_rdata;

    assign s_tready = (state_reg == spq_pkg::ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign is_deq   = (s_tuser[0] == spq_pkg::OP_DEQ);
    assign full     = (count_reg == CNT_W'(spq_pkg::CAPACITY));
    assign any_held = (count_reg != '0);
    assign enq_lvl  = spq_pkg::level_of(s_tdata[18:16]);

    // Highest level that holds anything
    always_comb
    begin
        top_lvl = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (lvl_cnt_reg[i] != '0)
            begin
                top_lvl = LVL_W'(i);
            end
        end
    end

    assign ram_we    = accept && !is_deq && !full;
    assign ram_waddr = {enq_lvl, tail_reg[enq_lvl]};
    assign ram_re    = accept && is_deq && any_held;
    assign ram_raddr = {top_lvl, head_reg[top_lvl]};

    spq_ram #(
        .WIDTH(spq_pkg::ID_W),
        .DEPTH(spq_pkg::MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata[15:0]),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        lvl_cnt_next    = lvl_cnt_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        deq_lvl_next    = deq_lvl_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_prio_next   = out_prio_reg;
        out_occ_next    = out_occ_reg;

        unique case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    out_id_next   = '0;
                    out_prio_next = '0;
                    if (!is_deq)
                    begin
                        out_valid_next = 1'b1;
                        if (full)
                        begin
                            out_status_next = spq_pkg::STAT_FULL;
                            out_occ_next    = spq_pkg::occ_of(count_reg);
                        end
                        else
                        begin
                            count_next              = count_reg + CNT_W'(1);
                            lvl_cnt_next[enq_lvl]   = lvl_cnt_reg[enq_lvl] + CNT_W'(1);
                            tail_next[enq_lvl]      = spq_pkg::ptr_inc(tail_reg[enq_lvl]);
                            out_status_next         = spq_pkg::STAT_ENQ;
                            out_occ_next            = spq_pkg::occ_of(count_reg + CNT_W'(1));
                        end
                    end
                    else if (!any_held)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = spq_pkg::STAT_EMPTY;
                        out_occ_next    = '0;
                    end
                    else
                    begin
                        // Pop bookkeeping now; the id arrives from the RAM next cycle
                        count_next            = count_reg - CNT_W'(1);
                        lvl_cnt_next[top_lvl] = lvl_cnt_reg[top_lvl] - CNT_W'(1);
                        head_next[top_lvl]    = spq_pkg::ptr_inc(head_reg[top_lvl]);
                        deq_lvl_next          = top_lvl;
                        state_next            = spq_pkg::ST_READ;
                    end
                end
            end
            spq_pkg::ST_READ:
            begin
                out_valid_next  = 1'b1;
                out_status_next = spq_pkg::STAT_DEQ;
                out_id_next     = ram_rdata;
                out_prio_next   = spq_pkg::PRIO_W'(deq_lvl_reg) + spq_pkg::PRIO_W'(1);
                out_occ_next    = spq_pkg::occ_of(count_reg);
                state_next      = spq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < LEVELS; i++)
            begin
                lvl_cnt_reg[i] <= '0;
                head_reg[i]    <= '0;
                tail_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            lvl_cnt_reg   <= lvl_cnt_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        deq_lvl_reg    <= deq_lvl_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_prio_reg   <= out_prio_next;
        out_occ_reg    <= out_occ_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_occ_reg, out_prio_reg, out_id_reg};

endmodule

// ----- hw/rtl/spq_checker.sv -----
module spq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // Held result must not change while the receiver stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Nothing removed: id and priority read as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != spq_pkg::STAT_DEQ |-> m_tdata[18:0] == '0)
        else $error("id or priority set on a result that removed nothing");

    // A real dequeue reports a priority within 1..LEVELS
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == spq_pkg::STAT_DEQ
            |-> m_tdata[18:16] != '0 && int'(m_tdata[18:16]) <= spq_pkg::LEVELS)
        else $error("dequeued priority out of range");

    // Refusals report the matching occupancy
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == spq_pkg::STAT_EMPTY |-> m_tdata[23:19] == '0)
        else $error("empty dequeue with non-zero occupancy");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == spq_pkg::STAT_FULL
            |-> m_tdata[23:19] == spq_pkg::OCC_W'(spq_pkg::CAPACITY))
        else $error("full enqueue with wrong occupancy");

endmodule

bind stable_priority_queue_core spq_checker u_spq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
